// File: rtl/mfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared types and defaults of the clipped-border box mean filter.
// ----------------------------------------------------------------------------
package mfw_pkg;

  localparam int DefMaxWidth    = 1024;
  localparam int DefMaxHeight   = 1024;
  localparam int DefMaxRadius   = 3;
  localparam int DefStoredLines = 8;

  localparam int CfgAddrWidth = 4;
  localparam int CfgDataWidth = 32;
  localparam int CfgRegWidth  = 11;
  localparam int CfgRadWidth  = 2;

  localparam logic [CfgRegWidth-1:0] ResetWidth  = 11'd1024;
  localparam logic [CfgRegWidth-1:0] ResetHeight = 11'd1024;
  localparam logic [CfgRadWidth-1:0] ResetRadius = 2'd1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_SETUP,
    ST_SETUP2,
    ST_IDLE,
    ST_ACCUM,
    ST_FLUSH,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] mean_value;
    logic       frame_last;
  } mean_out_t;

endpackage

// File: rtl/mean_filter_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_filter_window
// Box mean filter over a square window, clipped at the image border.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in channel (valid/ready), followed by
// R*W+R drain transactions that flush the frame. Output k leaves on the out
// channel once input k+R*W+R has been taken; frame_last marks the final pixel.
// Each producing input walks the (2R+1)x(2R+1) window, one line store read per
// cycle for each position inside the image, then a restoring divider gives the
// mean one bit per cycle over SW, the sum width (14 bits at default sizes).
// The window walk over the single read port and the divider hold an item with
// a result through ST_ACCUM, ST_FLUSH, ST_DIV, ST_WAIT and ST_OUT; an item
// without a result stays in ST_IDLE. The block takes one item at a time.
// The result sits in an output register: a stalled receiver does not stop
// the next input from being taken, but the block stalls once that next
// result is ready and the register is still full.
// Reset and every configuration write restart the frame and pass ST_SETUP and
// ST_SETUP2, working out the frame sizes, before input is taken again.
// ----------------------------------------------------------------------------
module mean_filter_window
  import mfw_pkg::*;
#(
  parameter int MAX_WIDTH    = DefMaxWidth,
  parameter int MAX_HEIGHT   = DefMaxHeight,
  parameter int MAX_RADIUS   = DefMaxRadius,
  parameter int STORED_LINES = DefStoredLines
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pix_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output mean_out_t               out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DW    = RW + 1;
  localparam int Depth = STORED_LINES * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int Side  = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(Side * Side * 255 + 1);
  localparam int CW    = $clog2(Side * Side + 1);

  state_e state_q, state_d;

  logic [CfgRegWidth-1:0] image_width_q, image_height_q;
  logic [CfgRadWidth-1:0] kernel_radius_q;
  logic                   cfg_wr;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;

  logic [PW-1:0]        pixels_q, lag_q, total_q;
  logic [AW-1:0]        lag_mod_q;
  logic signed [AW+1:0] rstep_q;

  logic [PW-1:0]        p_q;
  logic [AW-1:0]        waddr_q, base_q, raddr_q;
  logic [WW-1:0]        kx_q;
  logic [HW-1:0]        ky_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic                 rd_pend_q;
  logic [SW-1:0]        sum_q;
  logic [CW-1:0]        cnt_q;
  logic                 last_q;
  logic [7:0]           mean_q;
  logic                 out_valid_q;
  mean_out_t            out_data_q;

  logic                 accept, skip, produce, win_end, in_img;
  logic                 store_we, store_re, div_start, out_load;
  logic [7:0]           rdata;
  logic                 div_done;
  logic [SW-1:0]        quot;
  logic signed [WW+1:0] nx;
  logic signed [HW+1:0] ny;
  logic signed [DW-1:0] r_s;
  logic signed [AW+1:0] step, rnext_raw;
  logic [AW-1:0]        rnext, rstart;
  logic [AW:0]          rstart_wrap;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_reg_e'(paddr[3:2]))
      REG_WIDTH:  prdata = CfgDataWidth'(image_width_q);
      REG_HEIGHT: prdata = CfgDataWidth'(image_height_q);
      REG_RADIUS: prdata = CfgDataWidth'(kernel_radius_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= ResetWidth;
      image_height_q  <= ResetHeight;
      kernel_radius_q <= ResetRadius;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[3:2]))
        REG_WIDTH:  image_width_q   <= pwdata[CfgRegWidth-1:0];
        REG_HEIGHT: image_height_q  <= pwdata[CfgRegWidth-1:0];
        REG_RADIUS: kernel_radius_q <= pwdata[CfgRadWidth-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  always_comb begin
    if (image_width_q == '0) w_eff = WW'(1);
    else if (int'(image_width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(image_width_q);
    if (image_height_q == '0) h_eff = HW'(1);
    else if (int'(image_height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(image_height_q);
    if (int'(kernel_radius_q) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(kernel_radius_q);
  end

  assign r_s = $signed(DW'(r_eff));

  // handshake and decode of the incoming transaction
  assign accept  = in_valid_i & in_ready_o;
  assign skip    = (p_q == '0) & in_data_i.kind;
  assign produce = !skip && (p_q < total_q) && (p_q >= lag_q);
  assign win_end = (dx_q == r_s) && (dy_q == r_s);

  // window position and read address walk
  assign nx = $signed((WW+2)'(kx_q)) + (WW+2)'(dx_q);
  assign ny = $signed((HW+2)'(ky_q)) + (HW+2)'(dy_q);
  assign in_img = (nx >= 0) && (nx < $signed((WW+2)'(w_eff))) &&
                  (ny >= 0) && (ny < $signed((HW+2)'(h_eff)));

  assign step = (dx_q == r_s) ? rstep_q : (AW+2)'(1);

  always_comb begin
    rnext_raw = $signed((AW+2)'(raddr_q)) + step;
    if (rnext_raw < 0) rnext = AW'(rnext_raw + (AW+2)'(Depth));
    else if (rnext_raw >= $signed((AW+2)'(Depth))) rnext = AW'(rnext_raw - (AW+2)'(Depth));
    else rnext = AW'(rnext_raw);
    rstart_wrap = {1'b0, base_q} + (AW+1)'(Depth) - {1'b0, lag_mod_q};
    if (base_q >= lag_mod_q) rstart = base_q - lag_mod_q;
    else rstart = AW'(rstart_wrap);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SETUP:  state_d = ST_SETUP2;
      ST_SETUP2: state_d = ST_IDLE;
      ST_IDLE:   if (accept && produce) state_d = ST_ACCUM;
      ST_ACCUM:  if (win_end) state_d = ST_FLUSH;
      ST_FLUSH:  state_d = ST_DIV;
      ST_DIV:    state_d = ST_WAIT;
      ST_WAIT:   if (div_done) state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_SETUP;
    endcase
    if (cfg_wr) state_d = ST_SETUP;
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    store_we   = 1'b0;
    store_re   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        store_we   = in_valid_i && !skip && (p_q < pixels_q);
      end
      ST_ACCUM: store_re = in_img;
      ST_DIV:   div_start = 1'b1;
      ST_OUT:   out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SETUP;
      p_q         <= '0;
      waddr_q     <= '0;
      base_q      <= '0;
      kx_q        <= '0;
      ky_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      rd_pend_q <= store_re;

      if (cfg_wr) begin
        p_q     <= '0;
        waddr_q <= '0;
        base_q  <= '0;
        kx_q    <= '0;
        ky_q    <= '0;
      end else begin
        if (accept && !skip) begin
          if (p_q >= total_q || p_q + 1'b1 >= total_q) begin
            p_q     <= '0;
            waddr_q <= '0;
          end else begin
            p_q     <= p_q + 1'b1;
            waddr_q <= (waddr_q == AW'(Depth - 1)) ? '0 : waddr_q + 1'b1;
          end
          if (p_q >= total_q) begin
            base_q <= '0;
            kx_q   <= '0;
            ky_q   <= '0;
          end
        end

        // advance the output position once the result is loaded
        if (out_load) begin
          if (last_q) begin
            base_q <= '0;
            kx_q   <= '0;
            ky_q   <= '0;
          end else begin
            base_q <= (base_q == AW'(Depth - 1)) ? '0 : base_q + 1'b1;
            if (kx_q + 1'b1 == w_eff) begin
              kx_q <= '0;
              ky_q <= ky_q + 1'b1;
            end else begin
              kx_q <= kx_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      pixels_q <= PW'(w_eff) * PW'(h_eff);
      lag_q    <= PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    end
    if (state_q == ST_SETUP2) begin
      total_q   <= pixels_q + lag_q;
      lag_mod_q <= AW'(lag_q);
      rstep_q   <= $signed((AW+2)'(w_eff)) - $signed((AW+2)'({r_eff, 1'b0}));
    end

    if (accept && produce) begin
      last_q  <= (p_q + 1'b1 == total_q);
      dx_q    <= -r_s;
      dy_q    <= -r_s;
      raddr_q <= rstart;
      sum_q   <= '0;
      cnt_q   <= '0;
    end

    if (state_q == ST_ACCUM) begin
      raddr_q <= rnext;
      if (dx_q == r_s) begin
        dx_q <= -r_s;
        dy_q <= dy_q + 1'b1;
      end else begin
        dx_q <= dx_q + 1'b1;
      end
    end

    if (rd_pend_q) begin
      sum_q <= sum_q + SW'(rdata);
      cnt_q <= cnt_q + 1'b1;
    end

    if (state_q == ST_WAIT && div_done) mean_q <= quot[7:0];

    if (out_load) begin
      out_data_q.mean_value <= mean_q;
      out_data_q.frame_last <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  mfw_line_store #(
    .Depth(Depth),
    .AddrW(AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(waddr_q),
    .wdata_i(in_data_i.kind ? 8'd0 : in_data_i.pixel_in),
    .re_i   (store_re),
    .raddr_i(raddr_q),
    .rdata_o(rdata)
  );

  mfw_divider #(
    .NumW(SW),
    .DenW(CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q),
    .den_i  (cnt_q),
    .done_o (div_done),
    .quot_o (quot)
  );

endmodule

// File: rtl/mfw_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_line_store
// Circular store of recent pixel lines, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfw_line_store #(
  parameter int Depth = 8192,
  parameter int AddrW = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mfw_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfw_divider #(
  parameter int NumW = 14,
  parameter int DenW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quot_q[NumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DenW'(trial - {1'b0, den_q});
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = DenW'(trial);
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the clipped-border box mean filter.
// ----------------------------------------------------------------------------
// Frames of random size, radius and content are streamed through the block,
// with stray drains and pixels mixed in and frames cut short. A scoreboard
// keeps its own copy of the line store and counters, computes each window
// mean and checks every output transaction in order. Registers are rewritten
// between frames over the APB port and read back.
// ----------------------------------------------------------------------------
module tb_top;
  import mfw_pkg::*;

  class mean_scoreboard;
    int unsigned img_w, img_h, rad;
    int unsigned taken;
    bit [7:0]    pix_store[8192];
    mean_out_t   pending[$];
    int          errors;

    function new();
      img_w = 1024; img_h = 1024; rad = 1;
      taken = 0; errors = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] error: %s", $realtime, msg);
      errors++;
    endfunction

    function void write_reg(cfg_reg_e r, int unsigned v);
      case (r)
        REG_WIDTH:  img_w = v & 11'h7ff;
        REG_HEIGHT: img_h = v & 11'h7ff;
        default:    rad   = v & 2'h3;
      endcase
      taken = 0;
    endfunction

    function int unsigned eff(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function bit [7:0] window_mean(int unsigned k, int unsigned w, int unsigned h,
                                   int unsigned r);
      int y, x, ny, nx;
      int unsigned acc, cnt;
      y = k / w; x = k % w; acc = 0; cnt = 0;
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
        ny = y + dy;
        if (ny < 0 || ny >= int'(h)) continue;
        for (int dx = -int'(r); dx <= int'(r); dx++) begin
          nx = x + dx;
          if (nx < 0 || nx >= int'(w)) continue;
          acc += pix_store[(ny * w + nx) % 8192];
          cnt++;
        end
      end
      return cnt ? acc / cnt : 0;
    endfunction

    function void note_input(pix_in_t t);
      int unsigned w, h, r, npix, lag, total;
      mean_out_t e;
      w = eff(img_w, 1, 1024); h = eff(img_h, 1, 1024); r = eff(rad, 0, 3);
      npix = w * h; lag = r * w + r; total = npix + lag;
      if (taken == 0 && t.kind) return;
      if (taken < npix) pix_store[taken % 8192] = t.kind ? 8'd0 : t.pixel_in;
      if (taken >= lag) begin
        e.mean_value = window_mean(taken - lag, w, h, r);
        e.frame_last = (taken - lag == npix - 1);
        pending.push_back(e);
      end
      taken = (taken + 1 >= total) ? 0 : taken + 1;
    endfunction

    function void check_result(mean_out_t got);
      mean_out_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result mean=%0d last=%0d",
                         got.mean_value, got.frame_last));
        return;
      end
      e = pending.pop_front();
      if (got.mean_value !== e.mean_value)
        report($sformatf("mean_value %0d, want %0d", got.mean_value, e.mean_value));
      if (got.frame_last !== e.frame_last)
        report($sformatf("frame_last %0d, want %0d", got.frame_last, e.frame_last));
    endfunction
  endclass

  localparam int unsigned CycleLimit = 4000000;

  logic                    clk;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  pix_in_t                 in_data;
  logic                    out_valid;
  logic                    out_ready;
  mean_out_t               out_data;
  logic                    psel, penable, pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  mean_scoreboard sb = new();
  int unsigned    cycles;
  int unsigned    hold_left;
  bit             steady;
  int unsigned    items_sent;

  mean_filter_window i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) sb.check_result(out_data);
    if (in_valid && in_ready) sb.note_input(in_data);
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver, with a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = steady || ($urandom_range(99) >= 15);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(bit kind, bit [7:0] px);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.kind = kind;
    in_data.pixel_in = px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_e r, logic [31:0] v);
    logic [31:0] mask;
    mask = (r == REG_RADIUS) ? 32'h3 : 32'h7ff;
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {r, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    sb.write_reg(r, v);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== (v & mask))
      sb.report($sformatf("reg %s reads %0h, want %0h", r.name(), prdata, v & mask));
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    settle();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_RADIUS, r);
  endtask

  // one frame, with stray items mixed in when noisy; cut short at random when allowed
  task automatic run_frame(bit noisy, bit may_cut);
    int unsigned w, h, r, npix, total, stop_at;
    w = sb.eff(sb.img_w, 1, 1024); h = sb.eff(sb.img_h, 1, 1024);
    r = sb.rad;
    npix = w * h; total = npix + r * w + r;
    stop_at = (may_cut && $urandom_range(99) < 8) ? $urandom_range(total - 1) : total;
    if (noisy && $urandom_range(9) == 0)
      repeat ($urandom_range(2, 1)) send_item(1'b1, 8'($urandom));
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (i < npix)
        send_item(noisy && $urandom_range(99) < 5, 8'($urandom));
      else
        send_item(!(noisy && $urandom_range(99) < 5), 8'($urandom));
      items_sent++;
    end
  endtask

  initial begin
    int unsigned frame_idx;
    rst_ni = 1'b0; in_valid = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycles = 0; hold_left = 0; steady = 1'b0; items_sent = 0;
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // small directed frame: border clipping, extremes, stray drains and pixels
    set_frame(3, 3, 1);
    send_item(1'b1, 8'hff);
    send_item(1'b0, 8'h00); send_item(1'b0, 8'hff); send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00); send_item(1'b1, 8'hff); send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h80); send_item(1'b0, 8'h01); send_item(1'b0, 8'hff);
    send_item(1'b1, 8'h00); send_item(1'b0, 8'h55);
    send_item(1'b1, 8'h00); send_item(1'b1, 8'h00);
    // single pixel image, radius zero
    set_frame(1, 1, 0);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h7f);

    frame_idx = 0;
    while (items_sent < 1450) begin
      steady = (frame_idx >= 1 && frame_idx < 4);
      case (frame_idx)
        2:  set_frame(0, 0, 2);
        3:  set_frame(2047, 1, 0);
        default: set_frame($urandom_range(12, 1), $urandom_range(10, 1),
                           $urandom_range(3));
      endcase
      // receiver holds off while the sender keeps offering items
      if (frame_idx == 0) hold_left = 400;
      run_frame(frame_idx != 3, frame_idx != 3);
      frame_idx++;
    end
    steady = 1'b0;
    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
